// ===== sv/nca_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nca_pkg
// Shared widths, field layout and register codes of the nearest center
// assignment core.
// ----------------------------------------------------------------------------
package nca_pkg;

  localparam int COORD_BITS = 16;
  localparam int CI_W       = 6;
  localparam int DI_W       = 4;
  localparam int NC_W       = 7;
  localparam int ND_W       = 5;
  localparam int PI_W       = 16;
  localparam int BC_W       = 6;
  localparam int DIST_W     = 18;

  // squared distance over at most 31 coordinates
  localparam int SUM_W  = 2 * COORD_BITS + ND_W;
  localparam int ROOT_W = (SUM_W + 1) / 2;

  localparam int IN_FIELDS_W = CI_W + DI_W + COORD_BITS;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = PI_W + BC_W + DIST_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_CLUSTERS = 2'd0,
    CFG_NUM_DIMS     = 2'd1
  } cfg_reg_e;

  localparam logic FUNC_CENTER = 1'b0;
  localparam logic FUNC_POINT  = 1'b1;

endpackage
`default_nettype wire

// ===== sv/nca_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nca_isqrt
// Iterative floor square root, one result bit per cycle (two radicand bits).
// ----------------------------------------------------------------------------
module nca_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [nca_pkg::SUM_W-1:0]   radicand_i,
  output logic                        done_o,
  output logic [nca_pkg::ROOT_W-1:0]  root_o
);
  import nca_pkg::*;

  localparam int TOP = ((SUM_W - 1) / 2) * 2;

  logic [SUM_W-1:0] x_q, res_q, bit_q;
  logic             busy_q, done_q;
  logic [SUM_W:0]   trial;
  logic             take;

  assign trial = {1'b0, res_q} + {1'b0, bit_q};
  assign take  = {1'b0, x_q} >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= radicand_i;
      res_q <= '0;
      bit_q <= SUM_W'(1) << TOP;
    end else if (busy_q) begin
      if (take) begin
        x_q   <= x_q - trial[SUM_W-1:0];
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[ROOT_W-1:0];

  // remainder of a floor root never exceeds twice the root
  a_root_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ({1'b0, x_q} <= {res_q, 1'b0}))
    else $error("isqrt remainder too large");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("isqrt done held");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("isqrt started while busy");

endmodule
`default_nettype wire

// ===== sv/nearest_centroid_assignment_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_centroid_assignment_core
// K-means assignment: stores centers and the current point, finds the
// nearest center for each completed point and reports its floor distance.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  s_axis   | in        | s_axis_tvalid_i/_tready_o  | tdata: ci, dim, coord; tuser: func
//  m_axis   | out       | m_axis_tvalid_o/_tready_i  | tdata: point, cluster, distance
//  cfg      | in        | cfg_valid_i/cfg_ready_o    | cfg_index_i, cfg_data_i
//
//  Center words and non-final point words are stored while the core stays idle.
//  A final point word stops the input while the core walks the centers, one
//  center-store read per cycle, through a 4-stage distance pipe and then the
//  square root unit. Reset sets both settings to 1.
//  Reset clears control, counters and output; the stores and pipe data are not cleared.
//  A stalled result sits in the output register; the next words are
//  still taken meanwhile, and a later result waits for it.
// ----------------------------------------------------------------------------
module nearest_centroid_assignment_core #(
  parameter int MAX_CLUSTERS = 64,
  parameter int MAX_DIMS     = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // cluster_index[5:0], dim_index[9:6], coord[25:10], zero pad
  input  logic [nca_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // func[0]
  input  logic [0:0]                       s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // point_index[15:0], best_cluster[21:16], distance[39:22]
  output logic [nca_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [nca_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [nca_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import nca_pkg::*;

  localparam int CL_W      = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int DIM_W     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CEN_DEPTH = 2 ** (CL_W + DIM_W);
  localparam int PT_DEPTH  = 2 ** DIM_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_ROOT,
    S_OUT
  } state_e;

  // input fields
  logic [CI_W-1:0]       in_ci;
  logic [DI_W-1:0]       in_di;
  logic [COORD_BITS-1:0] in_coord;
  logic                  in_func;

  assign in_ci    = s_axis_tdata_i[CI_W-1:0];
  assign in_di    = s_axis_tdata_i[CI_W +: DI_W];
  assign in_coord = s_axis_tdata_i[CI_W+DI_W +: COORD_BITS];
  assign in_func  = s_axis_tuser_i[0];

  // configuration
  logic [NC_W-1:0] num_clusters_q;
  logic [ND_W-1:0] num_dims_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_clusters_q <= NC_W'(1);
      num_dims_q     <= ND_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_NUM_CLUSTERS: num_clusters_q <= cfg_data_i[NC_W-1:0];
        CFG_NUM_DIMS:     num_dims_q     <= cfg_data_i[ND_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CL_W-1:0]  last_c;
  logic [DIM_W-1:0] last_d;

  always_comb begin
    if (num_clusters_q == '0) begin
      last_c = '0;
    end else if (int'(num_clusters_q) > MAX_CLUSTERS) begin
      last_c = CL_W'(MAX_CLUSTERS - 1);
    end else begin
      last_c = CL_W'(num_clusters_q - NC_W'(1));
    end
    if (num_dims_q == '0) begin
      last_d = '0;
    end else if (int'(num_dims_q) > MAX_DIMS) begin
      last_d = DIM_W'(MAX_DIMS - 1);
    end else begin
      last_d = DIM_W'(num_dims_q - ND_W'(1));
    end
  end

  // control
  state_e              state_q, state_d;
  logic [CL_W-1:0]     c_q, c_d;
  logic [DIM_W-1:0]    d_q, d_d;
  logic [PI_W-1:0]     pt_cnt_q, pt_cnt_d;
  logic                m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q;

  logic s_acc, ci_ok, di_ok, cen_we, pt_we, trig;
  logic issue, iss_last, iss_final, out_load, root_start, root_done;
  logic fin_q;
  logic [ROOT_W-1:0] root;
  logic [SUM_W-1:0]  best_q;
  logic [CL_W-1:0]   best_c_q;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_acc      = s_axis_tvalid_i && s_axis_tready_o;
  assign ci_ok      = int'(in_ci) < MAX_CLUSTERS;
  assign di_ok      = int'(in_di) < MAX_DIMS;
  assign cen_we     = s_acc && (in_func == FUNC_CENTER) && ci_ok && di_ok;
  assign pt_we      = s_acc && (in_func == FUNC_POINT) && di_ok;
  assign trig       = s_acc && (in_func == FUNC_POINT) && (8'(in_di) == 8'(last_d));
  assign issue      = (state_q == S_WALK);
  assign iss_last   = (d_q == last_d);
  assign iss_final  = iss_last && (c_q == last_c);
  assign out_load   = (state_q == S_OUT) && (!m_valid_q || m_axis_tready_i);
  assign root_start = (state_q == S_DRAIN) && fin_q;

  always_comb begin
    state_d   = state_q;
    c_d       = c_q;
    d_d       = d_q;
    pt_cnt_d  = pt_cnt_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    unique case (state_q)
      S_IDLE: begin
        if (trig) begin
          state_d = S_WALK;
          c_d     = '0;
          d_d     = '0;
        end
      end
      S_WALK: begin
        if (iss_final) begin
          state_d = S_DRAIN;
        end else if (iss_last) begin
          d_d = '0;
          c_d = c_q + CL_W'(1);
        end else begin
          d_d = d_q + DIM_W'(1);
        end
      end
      S_DRAIN: begin
        if (fin_q) state_d = S_ROOT;
      end
      S_ROOT: begin
        if (root_done) state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_d   = S_IDLE;
          m_valid_d = 1'b1;
          pt_cnt_d  = pt_cnt_q + PI_W'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      c_q       <= '0;
      d_q       <= '0;
      pt_cnt_q  <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      state_q   <= state_d;
      c_q       <= c_d;
      d_q       <= d_d;
      pt_cnt_q  <= pt_cnt_d;
      m_valid_q <= m_valid_d;
      if (out_load) begin
        m_data_q <= OUT_DATA_W'({root[DIST_W-1:0], BC_W'(best_c_q), pt_cnt_q});
      end
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // stores
  logic [COORD_BITS-1:0] cen_mem [CEN_DEPTH];
  logic [COORD_BITS-1:0] pt_mem  [PT_DEPTH];
  logic [COORD_BITS-1:0] cen_rd_q, pt_rd_q;

  always_ff @(posedge clk_i) begin
    if (cen_we) cen_mem[{CL_W'(in_ci), DIM_W'(in_di)}] <= in_coord;
    cen_rd_q <= cen_mem[{c_q, d_q}];
  end

  always_ff @(posedge clk_i) begin
    if (pt_we) pt_mem[DIM_W'(in_di)] <= in_coord;
    pt_rd_q <= pt_mem[d_q];
  end

  // distance pipe: read, |diff|, square, accumulate/compare
  logic            s1_vld_q, s2_vld_q, s3_vld_q;
  logic            s1_first_q, s2_first_q, s3_first_q;
  logic            s1_last_q, s2_last_q, s3_last_q;
  logic            s1_final_q, s2_final_q, s3_final_q;
  logic [CL_W-1:0] s1_c_q, s2_c_q, s3_c_q;

  logic signed [COORD_BITS:0] diff;
  logic [COORD_BITS:0]        mag_full;
  logic [COORD_BITS-1:0]      mag_q;
  logic [2*COORD_BITS-1:0]    sq_q;
  logic [SUM_W-1:0]           acc_q, acc_sum;
  logic                       take_best;

  assign diff     = $signed({pt_rd_q[COORD_BITS-1], pt_rd_q})
                  - $signed({cen_rd_q[COORD_BITS-1], cen_rd_q});
  assign mag_full = diff[COORD_BITS] ? $unsigned(-diff) : $unsigned(diff);
  assign acc_sum  = (s3_first_q ? '0 : acc_q) + SUM_W'(sq_q);
  assign take_best = s3_vld_q && s3_last_q && ((s3_c_q == '0) || (acc_sum < best_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      fin_q    <= 1'b0;
    end else begin
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      fin_q    <= s3_vld_q && s3_final_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_first_q <= (d_q == '0);
    s1_last_q  <= iss_last;
    s1_final_q <= iss_final;
    s1_c_q     <= c_q;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s2_final_q <= s1_final_q;
    s2_c_q     <= s1_c_q;
    s3_first_q <= s2_first_q;
    s3_last_q  <= s2_last_q;
    s3_final_q <= s2_final_q;
    s3_c_q     <= s2_c_q;
    mag_q      <= mag_full[COORD_BITS-1:0];
    sq_q       <= mag_q * mag_q;
    if (s3_vld_q) acc_q <= acc_sum;
    if (take_best) begin
      best_q   <= acc_sum;
      best_c_q <= s3_c_q;
    end
  end

  nca_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start),
    .radicand_i (best_q),
    .done_o     (root_done),
    .root_o     (root)
  );

  a_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |-> !(s1_vld_q || s2_vld_q || s3_vld_q || fin_q))
    else $error("word accepted while distance pipe busy");

  a_fin_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> (state_q == S_DRAIN))
    else $error("walk finished outside drain");

  a_pt_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (pt_cnt_q == $past(pt_cnt_q) + PI_W'(1)))
    else $error("point counter not advanced on result");

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for nearest_centroid_assignment_core: loads centers and
// points over the input stream, predicts each assignment (point number,
// nearest center, floor distance) and compares every output word with it.
// ----------------------------------------------------------------------------
module tb_top;
  import nca_pkg::*;

  localparam int LIMIT       = 2_000_000;
  localparam int N_RANDOM    = 1350;
  localparam int SETTLE      = 64;
  localparam int NC_MAX      = 64;
  localparam int ND_MAX      = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [PI_W-1:0]   pnum;
    logic [BC_W-1:0]   center;
    logic [DIST_W-1:0] distance;
  } assign_t;

  typedef enum {ROW_WORD, ROW_CFG} row_kind_e;
  typedef enum {CHK_PRED, CHK_NONE, CHK_TYPED} check_e;
  typedef enum {MODE_WIDE, MODE_SMALL, MODE_EDGE, MODE_FAR} coord_mode_e;

  typedef struct {
    row_kind_e                 kind;
    logic [CFG_IDX_W-1:0]      reg_idx;
    logic [CFG_DATA_W-1:0]     reg_val;
    logic                      func;
    logic [CI_W-1:0]           ci;
    logic [DI_W-1:0]           di;
    logic signed [COORD_BITS-1:0] coord;
    check_e                    chk;
    assign_t                   want;
  } step_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid_i = 1'b0;
  logic                    s_axis_tready_o;
  logic [IN_DATA_W-1:0]    s_axis_tdata_i = '0;
  logic [0:0]              s_axis_tuser_i = '0;
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0]   m_axis_tdata_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i = '0;

  nearest_centroid_assignment_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // predictor state
  logic signed [COORD_BITS-1:0] center_mem [NC_MAX][ND_MAX];
  logic signed [COORD_BITS-1:0] point_mem [ND_MAX];
  bit                           center_seen [NC_MAX][ND_MAX];
  bit                           point_seen [ND_MAX];
  logic [PI_W-1:0]              point_num = '0;
  logic [NC_W-1:0]              reg_clusters = NC_W'(1);
  logic [ND_W-1:0]              reg_dims = ND_W'(1);

  assign_t pending_assign [$];
  int      n_err = 0;
  int      n_words = 0;
  int      n_checked = 0;
  int      n_cfg = 0;
  int      cycles = 0;
  bit      steady = 1'b0;

  task automatic flag(input string msg);
    $display("ERROR: %s", msg);
    n_err++;
  endtask

  function automatic int span(input int v, input int hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [DIST_W-1:0] floor_root(input longint unsigned x);
    longint unsigned r, t;
    r = 0;
    for (int b = 19; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r[DIST_W-1:0];
  endfunction

  task automatic predict_word(input logic func, input logic [CI_W-1:0] ci,
                              input logic [DI_W-1:0] di,
                              input logic signed [COORD_BITS-1:0] v,
                              output bit fired, output assign_t r);
    int k, dd, diff, win;
    longint unsigned s, best;
    fired = 1'b0;
    r = '0;
    if (func == FUNC_CENTER) begin
      center_mem[ci][di] = v;
      center_seen[ci][di] = 1'b1;
      return;
    end
    point_mem[di] = v;
    point_seen[di] = 1'b1;
    k  = span(reg_clusters, NC_MAX);
    dd = span(reg_dims, ND_MAX);
    if (int'(di) != dd - 1) return;
    best = 0;
    win = 0;
    for (int c = 0; c < k; c++) begin
      s = 0;
      for (int d = 0; d < dd; d++) begin
        diff = int'(point_mem[d]) - int'(center_mem[c][d]);
        s += longint'(diff) * longint'(diff);
      end
      if (c == 0 || s < best) begin
        best = s;
        win = c;
      end
    end
    r.pnum     = point_num;
    r.center   = BC_W'(win);
    r.distance = floor_root(best);
    point_num++;
    fired = 1'b1;
  endtask

  // ---- drivers ----
  task automatic send_word(input logic func, input int ci, input int di, input int coord,
                           output bit fired, output assign_t r);
    logic signed [COORD_BITS-1:0] v;
    v = COORD_BITS'(coord);
    @(negedge clk_i);
    if (!steady && $urandom_range(99) < 35) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = func;
    s_axis_tdata_i  = IN_DATA_W'({v, DI_W'(di), CI_W'(ci)});
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_word(func, CI_W'(ci), DI_W'(di), v, fired, r);
    n_words++;
  endtask

  task automatic push_word(input logic func, input int ci, input int di, input int coord);
    bit fired;
    assign_t r;
    send_word(func, ci, di, coord, fired, r);
    if (fired) pending_assign.insert(pending_assign.size(), r);
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (pending_assign.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    settle();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = CFG_DATA_W'(val);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_NUM_CLUSTERS: reg_clusters = cfg_data_i[NC_W-1:0];
      CFG_NUM_DIMS:     reg_dims = cfg_data_i[ND_W-1:0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  always @(negedge clk_i) begin
    m_axis_tready_i <= steady || ($urandom_range(99) >= 35);
  end

  // ---- result checker ----
  always @(posedge clk_i) begin : check_out
    assign_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.pnum     = m_axis_tdata_o[PI_W-1:0];
      got.center   = m_axis_tdata_o[PI_W+BC_W-1:PI_W];
      got.distance = m_axis_tdata_o[PI_W+BC_W+DIST_W-1:PI_W+BC_W];
      if (pending_assign.size() == 0) begin
        flag($sformatf("result with nothing pending: point %0d", got.pnum));
      end else begin
        want = pending_assign.pop_front();
        n_checked++;
        if (got.pnum != want.pnum)
          flag($sformatf("point_index %0d, want %0d", got.pnum, want.pnum));
        if (got.center != want.center)
          flag($sformatf("point %0d best_cluster %0d, want %0d",
                         want.pnum, got.center, want.center));
        if (got.distance != want.distance)
          flag($sformatf("point %0d distance %0d, want %0d",
                         want.pnum, got.distance, want.distance));
      end
    end
  end

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycles, pending_assign.size());
    $display("FAIL");
    $finish;
  end

  // ---- directed table ----
  step_t dir_tab [$];

  task automatic add_row(input step_t s);
    dir_tab.insert(dir_tab.size(), s);
  endtask

  function automatic step_t word_row(input logic func, input int ci, input int di,
                                     input int coord, input check_e chk,
                                     input int pnum = 0, input int center = 0,
                                     input int distance = 0);
    step_t s;
    s.kind    = ROW_WORD;
    s.reg_idx = '0;
    s.reg_val = '0;
    s.func    = func;
    s.ci      = CI_W'(ci);
    s.di      = DI_W'(di);
    s.coord   = COORD_BITS'(coord);
    s.chk     = chk;
    s.want.pnum     = PI_W'(pnum);
    s.want.center   = BC_W'(center);
    s.want.distance = DIST_W'(distance);
    return s;
  endfunction

  function automatic step_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
    step_t s;
    s = word_row(FUNC_CENTER, 0, 0, 0, CHK_NONE);
    s.kind    = ROW_CFG;
    s.reg_idx = idx;
    s.reg_val = CFG_DATA_W'(val);
    return s;
  endfunction

  function automatic int pick_coord(input coord_mode_e md, input logic func);
    int edges [5];
    edges = '{-32768, -1, 0, 1, 32767};
    case (md)
      MODE_SMALL: return int'($urandom_range(16)) - 8;
      MODE_EDGE:  return edges[$urandom_range(4)];
      MODE_FAR:   return (func == FUNC_CENTER) ? -32768 : 32767;
      default:    return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  int          plan_k [10] = '{3, 127, 2, 8, 0, 64, 5, 16, 4, 1};
  int          plan_d [10] = '{2, 1, 31, 4, 5, 2, 0, 8, 7'h63, 16};
  coord_mode_e plan_m [10] = '{MODE_SMALL, MODE_WIDE, MODE_FAR, MODE_SMALL, MODE_WIDE,
                               MODE_SMALL, MODE_WIDE, MODE_EDGE, MODE_WIDE, MODE_WIDE};

  initial begin : stimulus
    bit          fired;
    assign_t     r;
    int          n_dir, kv, dv, k, dd, ph, npts;
    coord_mode_e md;

    // reset state: one center, one coordinate
    add_row(word_row(FUNC_CENTER, 0, 0, 0, CHK_NONE));
    add_row(word_row(FUNC_POINT, 0, 0, 32767, CHK_TYPED, 0, 0, 32767));
    add_row(word_row(FUNC_POINT, 0, 0, -32768, CHK_TYPED, 1, 0, 32768));
    add_row(word_row(FUNC_CENTER, 0, 0, -32768, CHK_NONE));
    add_row(word_row(FUNC_POINT, 5, 0, 32767, CHK_TYPED, 2, 0, 65535));
    add_row(word_row(FUNC_CENTER, 63, 15, -1, CHK_NONE));
    add_row(word_row(FUNC_CENTER, 1, 0, 32767, CHK_NONE));
    add_row(cfg_row(CFG_NUM_CLUSTERS, 2));
    add_row(word_row(FUNC_POINT, 0, 0, 32767, CHK_TYPED, 3, 1, 0));
    // equal distances keep the lower center
    add_row(word_row(FUNC_CENTER, 1, 0, -32768, CHK_NONE));
    add_row(word_row(FUNC_POINT, 63, 0, 0, CHK_TYPED, 4, 0, 32768));
    add_row(cfg_row(CFG_NUM_DIMS, 2));
    add_row(word_row(FUNC_CENTER, 0, 1, 0, CHK_NONE));
    add_row(word_row(FUNC_CENTER, 1, 1, 100, CHK_NONE));
    add_row(word_row(FUNC_POINT, 0, 0, 7, CHK_NONE));
    add_row(word_row(FUNC_POINT, 0, 1, 0, CHK_PRED));
    add_row(word_row(FUNC_POINT, 0, 3, 5, CHK_NONE));
    // stale coordinate 0 reused
    add_row(word_row(FUNC_POINT, 0, 1, 100, CHK_PRED));
    add_row(cfg_row(CFG_SPARE_2, 127));
    add_row(cfg_row(CFG_SPARE_3, 0));
    add_row(cfg_row(CFG_NUM_CLUSTERS, 0));
    add_row(cfg_row(CFG_NUM_DIMS, 0));
    add_row(word_row(FUNC_POINT, 0, 0, -32768, CHK_TYPED, 7, 0, 0));
    add_row(word_row(FUNC_POINT, 0, 5, 1, CHK_NONE));

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      end else begin
        send_word(dir_tab[i].func, dir_tab[i].ci, dir_tab[i].di, dir_tab[i].coord, fired, r);
        case (dir_tab[i].chk)
          CHK_PRED:  if (fired) pending_assign.insert(pending_assign.size(), r);
          CHK_TYPED: pending_assign.insert(pending_assign.size(), dir_tab[i].want);
          default: ;
        endcase
      end
    end
    n_dir = n_words;

    // random phases: settings, center load, then points with noise
    for (ph = 0; n_words - n_dir < N_RANDOM; ph++) begin
      if (ph < 10) begin
        kv = plan_k[ph];
        dv = plan_d[ph];
        md = plan_m[ph];
      end else begin
        kv = $urandom_range(1, 10);
        dv = $urandom_range(1, 6);
        md = coord_mode_e'($urandom_range(2));
      end
      write_reg(CFG_NUM_CLUSTERS, kv);
      write_reg(CFG_NUM_DIMS, dv);
      steady = (ph == 3 || ph == 5);
      k  = span(kv & 7'h7F, NC_MAX);
      dd = span(dv & 5'h1F, ND_MAX);
      for (int c = 0; c < k; c++)
        for (int d = 0; d < dd; d++)
          if (!center_seen[c][d] || md == MODE_FAR || $urandom_range(3) == 0)
            push_word(FUNC_CENTER, c, d, pick_coord(md, FUNC_CENTER));
      npts = $urandom_range(3, 10);
      repeat (npts) begin
        for (int d = 0; d < dd; d++) begin
          if (d < dd - 1 && point_seen[d] && $urandom_range(99) < 15) continue;
          if ($urandom_range(99) < 8) begin
            if (dd < ND_MAX && $urandom_range(1) == 0)
              push_word(FUNC_POINT, $urandom_range(63), $urandom_range(dd, ND_MAX - 1),
                        pick_coord(md, FUNC_POINT));
            else
              push_word(FUNC_CENTER, $urandom_range(NC_MAX - 1), $urandom_range(ND_MAX - 1),
                        pick_coord(md, FUNC_CENTER));
          end
          push_word(FUNC_POINT, $urandom_range(63), d, pick_coord(md, FUNC_POINT));
        end
      end
    end
    steady = 1'b0;
    settle();

    $display("run: %0d words (%0d directed), %0d phases, %0d register writes",
             n_words, n_dir, ph, n_cfg);
    $display("run: %0d assignments checked, %0d errors", n_checked, n_err);
    if (n_err == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== nearest_centroid_assignment_core.f =====
sv/nca_pkg.sv
sv/nca_isqrt.sv
sv/nearest_centroid_assignment_core.sv
bench/tb_top.sv
